>>> design/llpm_pkg.sv
// Package for the linked list pool manager.
// Holds the transaction payload structs, command and status codes and the sequencer states.
`timescale 1ns / 1ps
package llpm_pkg;

    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;

    localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_HEAD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_TAIL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DEL_ALL   = 3'd7;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    slot;
        logic [REMOVED_W-1:0] removed;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FREE_RD,
        ST_FREE_CAP,
        ST_WALK_RD,
        ST_WALK_CAP,
        ST_INS_W1,
        ST_INS_W2,
        ST_NX_RD,
        ST_NX_CAP,
        ST_UNLINK,
        ST_RELEASE,
        ST_DONE
    } t_state;

endpackage

>>> design/linked_list_pool_manager.sv
// Top level of the linked list pool manager: command sequencer, list registers and stores.
// Depends on llpm_pkg, llpm_link and llpm_ram.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (mode, value, position)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (status, slot, removed)
//
// One command is in flight at a time. A rejected positional command (full pool, empty
// list, bad position) goes from the start state straight to the done state. A walk reads
// and then captures each link in turn, since the link store has registered read data. A
// match delete reads each node in the same way and unlinks and releases each match.
// Reset is synchronous and active low; the pool is usable on the first cycle after it.
// A waiting result holds the next command in its final state until the output drains.
module linked_list_pool_manager #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  llpm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output llpm_pkg::t_out o_out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = PW + 6;
    localparam int VW = (DATA_WIDTH < llpm_pkg::VALUE_W) ? DATA_WIDTH : llpm_pkg::VALUE_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

    llpm_pkg::t_state r_state, n_state;

    // List bookkeeping.
    logic [PW-1:0] r_head, r_free, r_nfree, r_len;
    logic [PW-1:0] r_prev, r_cur, r_nx, r_slot;
    logic [CW-1:0] r_cnt;

    // Command and result registers.
    logic [llpm_pkg::MODE_W-1:0]    r_mode;
    logic [DATA_WIDTH-1:0]          r_val;
    logic [llpm_pkg::POS_W-1:0]     r_pos;
    logic [llpm_pkg::STATUS_W-1:0]  r_status;
    logic [PW-1:0]                  r_removed;
    logic                           r_ovalid;
    llpm_pkg::t_out                 r_out;

    // Store ports.
    logic                  w_lk_wr, w_lk_rd, w_val_wr;
    logic [IW-1:0]         w_lk_waddr, w_rd_addr;
    logic [PW-1:0]         w_lk_wdata, w_lk_q;
    logic [DATA_WIDTH-1:0] w_val_q;

    // Command decode.
    logic          w_is_ins, w_is_match, w_single_end, w_out_free, w_hit;
    logic [CW-1:0] w_p, w_len_c;

    assign w_is_ins   = (r_mode == llpm_pkg::MODE_INS_HEAD) || (r_mode == llpm_pkg::MODE_INS_TAIL)
                     || (r_mode == llpm_pkg::MODE_INS_POS);
    assign w_is_match = (r_mode == llpm_pkg::MODE_DEL_FIRST) || (r_mode == llpm_pkg::MODE_DEL_ALL);
    // A release ends the command unless it is a delete-all sweep.
    assign w_single_end = (r_mode != llpm_pkg::MODE_DEL_ALL);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_hit      = (w_val_q == r_val);
    assign w_len_c    = CW'(r_len);

    // Target position of a command, one-based.
    always_comb begin
        case (r_mode) inside
            llpm_pkg::MODE_INS_HEAD, llpm_pkg::MODE_DEL_HEAD: w_p = CW'(1);
            llpm_pkg::MODE_INS_TAIL:                          w_p = w_len_c + CW'(1);
            llpm_pkg::MODE_DEL_TAIL:                          w_p = w_len_c;
            default:                                          w_p = CW'(r_pos);
        endcase
    end

    assign o_in_ready = (r_state == llpm_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llpm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = llpm_pkg::ST_START;
                end
            end
            llpm_pkg::ST_START: begin
                if (w_is_ins) begin
                    if (r_free == NULL_PTR || w_p == '0 || w_p > w_len_c + CW'(1)) begin
                        n_state = llpm_pkg::ST_DONE;
                    end else begin
                        n_state = llpm_pkg::ST_FREE_RD;
                    end
                end else if (w_is_match) begin
                    n_state = llpm_pkg::ST_NX_RD;
                end else if (r_len == '0 || w_p == '0 || w_p > w_len_c) begin
                    n_state = llpm_pkg::ST_DONE;
                end else begin
                    n_state = llpm_pkg::ST_WALK_RD;
                end
            end
            llpm_pkg::ST_FREE_RD:  n_state = llpm_pkg::ST_FREE_CAP;
            llpm_pkg::ST_FREE_CAP: n_state = llpm_pkg::ST_WALK_RD;
            llpm_pkg::ST_WALK_RD: begin
                if (r_cnt != '0) begin
                    n_state = llpm_pkg::ST_WALK_CAP;
                end else if (w_is_ins) begin
                    n_state = llpm_pkg::ST_INS_W1;
                end else begin
                    n_state = llpm_pkg::ST_NX_RD;
                end
            end
            llpm_pkg::ST_WALK_CAP: n_state = llpm_pkg::ST_WALK_RD;
            llpm_pkg::ST_INS_W1:   n_state = llpm_pkg::ST_INS_W2;
            llpm_pkg::ST_INS_W2:   n_state = llpm_pkg::ST_DONE;
            llpm_pkg::ST_NX_RD: begin
                if (r_cur == NULL_PTR) begin
                    n_state = llpm_pkg::ST_DONE;
                end else begin
                    n_state = llpm_pkg::ST_NX_CAP;
                end
            end
            llpm_pkg::ST_NX_CAP: begin
                if (!w_is_match || w_hit) begin
                    n_state = llpm_pkg::ST_UNLINK;
                end else begin
                    n_state = llpm_pkg::ST_NX_RD;
                end
            end
            llpm_pkg::ST_UNLINK: n_state = llpm_pkg::ST_RELEASE;
            llpm_pkg::ST_RELEASE: begin
                if (w_single_end) begin
                    n_state = llpm_pkg::ST_DONE;
                end else begin
                    n_state = llpm_pkg::ST_NX_RD;
                end
            end
            llpm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = llpm_pkg::ST_IDLE;
                end
            end
            default: n_state = llpm_pkg::ST_IDLE;
        endcase
    end

    // Store controls.
    always_comb begin
        w_lk_wr    = 1'b0;
        w_lk_waddr = r_cur[IW-1:0];
        w_lk_wdata = r_free;
        w_lk_rd    = 1'b0;
        w_rd_addr  = r_cur[IW-1:0];
        w_val_wr   = 1'b0;
        unique case (r_state)
            llpm_pkg::ST_FREE_RD: begin
                w_lk_rd   = 1'b1;
                w_rd_addr = r_free[IW-1:0];
            end
            llpm_pkg::ST_WALK_RD: w_lk_rd = (r_cnt != '0);
            llpm_pkg::ST_NX_RD:   w_lk_rd = (r_cur != NULL_PTR);
            llpm_pkg::ST_INS_W1: begin
                w_lk_wr    = 1'b1;
                w_lk_waddr = r_slot[IW-1:0];
                w_lk_wdata = r_cur;
                w_val_wr   = 1'b1;
            end
            llpm_pkg::ST_INS_W2: begin
                w_lk_wr    = (r_prev != NULL_PTR);
                w_lk_waddr = r_prev[IW-1:0];
                w_lk_wdata = r_slot;
            end
            llpm_pkg::ST_UNLINK: begin
                w_lk_wr    = (r_prev != NULL_PTR);
                w_lk_waddr = r_prev[IW-1:0];
                w_lk_wdata = r_nx;
            end
            llpm_pkg::ST_RELEASE: w_lk_wr = 1'b1;
            default: begin
            end
        endcase
    end

    llpm_link #(.DEPTH(DEPTH)) u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_lk_wr),
        .i_wr_addr (w_lk_waddr),
        .i_wr_data (w_lk_wdata),
        .i_rd_en   (w_lk_rd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_lk_q)
    );

    // Node values are read whenever the link store is read, also for the free slot an insert takes.
    llpm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_values (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_wr),
        .i_wr_addr (r_slot[IW-1:0]),
        .i_wr_data (r_val),
        .i_rd_en   (w_lk_rd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_val_q)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llpm_pkg::ST_IDLE;
            r_head   <= NULL_PTR;
            r_free   <= PW'(DEPTH - 1);
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // A result loads the output register when it is empty or draining.
            if (r_state == llpm_pkg::ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                llpm_pkg::ST_INS_W2: begin
                    if (r_prev == NULL_PTR) begin
                        r_head <= r_slot;
                    end
                    r_free <= r_nfree;
                    r_len  <= r_len + PW'(1);
                end
                llpm_pkg::ST_UNLINK: begin
                    if (r_prev == NULL_PTR) begin
                        r_head <= r_nx;
                    end
                end
                llpm_pkg::ST_RELEASE: begin
                    r_free <= r_cur;
                    r_len  <= r_len - PW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the command.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            llpm_pkg::ST_IDLE: begin
                r_mode <= i_in_data.mode;
                r_val  <= DATA_WIDTH'(i_in_data.value[VW-1:0]);
                r_pos  <= i_in_data.position;
            end
            llpm_pkg::ST_START: begin
                r_removed <= '0;
                r_slot    <= r_free;
                r_prev    <= NULL_PTR;
                r_cur     <= r_head;
                r_cnt     <= w_p - CW'(1);
                if (w_is_ins) begin
                    if (r_free == NULL_PTR) begin
                        r_status <= llpm_pkg::STAT_FULL;
                    end else if (w_p == '0 || w_p > w_len_c + CW'(1)) begin
                        r_status <= llpm_pkg::STAT_BAD_POS;
                    end else begin
                        r_status <= llpm_pkg::STAT_DONE;
                    end
                end else if (w_is_match || r_len == '0) begin
                    r_status <= llpm_pkg::STAT_EMPTY;
                end else if (w_p == '0 || w_p > w_len_c) begin
                    r_status <= llpm_pkg::STAT_BAD_POS;
                end else begin
                    r_status <= llpm_pkg::STAT_DONE;
                end
            end
            llpm_pkg::ST_FREE_CAP: r_nfree <= w_lk_q;
            llpm_pkg::ST_WALK_CAP: begin
                r_prev <= r_cur;
                r_cur  <= w_lk_q;
                r_cnt  <= r_cnt - CW'(1);
            end
            llpm_pkg::ST_NX_CAP: begin
                r_nx <= w_lk_q;
                if (w_is_match && !w_hit) begin
                    r_prev <= r_cur;
                    r_cur  <= w_lk_q;
                end
            end
            llpm_pkg::ST_RELEASE: begin
                r_removed <= r_removed + PW'(1);
                r_status  <= llpm_pkg::STAT_DONE;
                r_cur     <= r_nx;
                if (r_mode == llpm_pkg::MODE_DEL_ALL) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_cur;
                end
            end
            llpm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_out.status  <= r_status;
                    r_out.slot    <= (r_status == llpm_pkg::STAT_DONE)
                                   ? llpm_pkg::SLOT_W'(r_slot) : '0;
                    r_out.removed <= llpm_pkg::REMOVED_W'(r_removed);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // The list never holds more nodes than the pool has slots.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= PW'(DEPTH))
        else $error("list length exceeds pool depth");

    // The free chain is empty exactly when the list fills the pool.
    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NULL_PTR) == (r_len == PW'(DEPTH)))
        else $error("free chain and list length disagree");

    // Nodes are only reported as removed on a successful command.
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.removed != '0) |-> (o_out_data.status == llpm_pkg::STAT_DONE))
        else $error("removed count on a failed command");
`endif

endmodule

>>> design/llpm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module llpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

>>> design/llpm_link.sv
// Link store: next pointers of all pool slots, with per-slot valid bits that supply
// the reset chain (slot i links to i-1, slot 0 to null). Uses llpm_ram.
`timescale 1ns / 1ps
module llpm_link #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [$clog2(DEPTH+1)-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [$clog2(DEPTH+1)-1:0] o_rd_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

    logic [DEPTH-1:0] r_vld;
    logic             r_rvld;
    logic [IW-1:0]    r_raddr;
    logic [PW-1:0]    w_q;

    llpm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_raddr <= i_rd_addr;
            r_rvld  <= r_vld[i_rd_addr];
        end
    end

    // Slots never written still carry the chain built at reset.
    assign o_rd_data = r_rvld ? w_q
                     : (r_raddr == '0) ? NULL_PTR : PW'(r_raddr) - PW'(1);

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the linked list pool manager.
// Depends on llpm_pkg and linked_list_pool_manager; predicts each result in a local list model.
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH     = 16;
    localparam int NIL       = DEPTH;
    localparam int MAX_CYC   = 400000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    llpm_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    llpm_pkg::t_out o_out_data;

    linked_list_pool_manager #(.DEPTH(DEPTH), .DATA_WIDTH(32)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    // Shadow copy of the pool: values, links and both chain heads.
    logic [31:0] pool_val [DEPTH];
    int          pool_nxt [DEPTH];
    int          list_hd;
    int          free_hd;

    llpm_pkg::t_in  cmd_q [$];      // commands waiting to be driven
    llpm_pkg::t_out result_q [$];   // predicted results in command order
    int   err_cnt;
    int   cyc;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   stim_done;
    int   len_shadow;     // list length as the stimulus generator tracks it

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int chain_len();
        int n;
        int c;
        n = 0;
        c = list_hd;
        while (c < DEPTH && n < DEPTH) begin
            n++;
            c = pool_nxt[c];
        end
        return n;
    endfunction

    // Walk to the node at one-based position p and the node in front of it.
    function automatic void seek(input int p, output int pv, output int c);
        pv = NIL;
        c = list_hd;
        for (int i = 1; i < p && i <= DEPTH; i++) begin
            pv = c;
            c = (c < DEPTH) ? pool_nxt[c] : NIL;
        end
    endfunction

    // Remove node c from the list and push its slot onto the free chain.
    function automatic void detach(input int pv, input int c);
        int nx;
        nx = (c < DEPTH) ? pool_nxt[c] : NIL;
        if (pv < DEPTH) begin
            pool_nxt[pv] = nx;
        end else begin
            list_hd = nx;
        end
        if (c < DEPTH) begin
            pool_nxt[c] = free_hd;
            free_hd = c;
        end
    endfunction

    // Apply one command to the shadow pool and return the result it must give.
    function automatic llpm_pkg::t_out apply_cmd(input llpm_pkg::t_in cmd);
        llpm_pkg::t_out r;
        int   len;
        int   p;
        int   pv;
        int   c;
        int   s;
        int   nx;
        int   guard;
        r = '0;
        len = chain_len();
        if (cmd.mode <= llpm_pkg::MODE_INS_POS) begin
            p = (cmd.mode == llpm_pkg::MODE_INS_HEAD) ? 1 :
                (cmd.mode == llpm_pkg::MODE_INS_TAIL) ? len + 1 : int'(cmd.position);
            if (free_hd >= DEPTH) begin
                r.status = llpm_pkg::STAT_FULL;
            end else if (p == 0 || p > len + 1) begin
                r.status = llpm_pkg::STAT_BAD_POS;
            end else begin
                seek(p, pv, c);
                s = free_hd;
                free_hd = pool_nxt[s];
                pool_val[s] = cmd.value;
                pool_nxt[s] = c;
                if (pv < DEPTH) begin
                    pool_nxt[pv] = s;
                end else begin
                    list_hd = s;
                end
                r.slot = s[3:0];
            end
        end else if (cmd.mode <= llpm_pkg::MODE_DEL_POS) begin
            p = (cmd.mode == llpm_pkg::MODE_DEL_HEAD) ? 1 :
                (cmd.mode == llpm_pkg::MODE_DEL_TAIL) ? len : int'(cmd.position);
            if (len == 0) begin
                r.status = llpm_pkg::STAT_EMPTY;
            end else if (p == 0 || p > len) begin
                r.status = llpm_pkg::STAT_BAD_POS;
            end else begin
                seek(p, pv, c);
                r.slot = c[3:0];
                detach(pv, c);
                r.removed = 5'd1;
            end
        end else begin
            guard = 0;
            pv = NIL;
            c = list_hd;
            while (c < DEPTH && guard < DEPTH) begin
                nx = pool_nxt[c];
                guard++;
                if (pool_val[c] == cmd.value) begin
                    detach(pv, c);
                    r.removed++;
                    if (cmd.mode == llpm_pkg::MODE_DEL_FIRST) begin
                        r.slot = c[3:0];
                        break;
                    end
                end else begin
                    pv = c;
                end
                c = nx;
            end
            if (r.removed == 0) begin
                r.status = llpm_pkg::STAT_EMPTY;
            end
        end
        return r;
    endfunction

    function automatic llpm_pkg::t_in mk_cmd(input logic [2:0] m, input logic [31:0] v,
                                             input logic [4:0] p);
        llpm_pkg::t_in t;
        t.mode = m;
        t.value = v;
        t.position = p;
        return t;
    endfunction

    // Values come from a small set most of the time so that match deletes hit,
    // with full-range noise mixed in to toggle every bit.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom();
        end
        return 32'(32'hA5A5_0000 + $urandom_range(0, 3)) ^ ({32{$urandom_range(0, 1) == 1}});
    endfunction

    // Random command biased toward positions that are legal for the current
    // list length; inserts dominate while the list is short, deletes when long.
    function automatic llpm_pkg::t_in rand_cmd();
        logic [2:0] m;
        logic [4:0] p;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 55 - 3 * len_shadow) begin
            m = 3'($urandom_range(0, 2));
        end else begin
            m = 3'($urandom_range(3, 7));
        end
        if ($urandom_range(0, 9) == 0) begin
            p = 5'($urandom_range(0, 31));
        end else begin
            p = 5'($urandom_range(1, len_shadow + 1));
        end
        return mk_cmd(m, pick_value(), p);
    endfunction

    // Stimulus generator. It keeps its own length count from the predicted
    // results so that random positions mostly land inside the list.
    initial begin
        llpm_pkg::t_in c;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        err_cnt = 0;
        stim_done = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 68;
        list_hd = NIL;
        free_hd = DEPTH - 1;
        len_shadow = 0;
        for (int i = 0; i < DEPTH; i++) begin
            pool_val[i] = '0;
            pool_nxt[i] = (i == 0) ? NIL : i - 1;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-list deletes, bad positions, extreme values,
        // filling the pool to overflow, then every delete kind.
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_HEAD, 32'd0, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_TAIL, 32'd0, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_POS, 32'd0, 5'd1));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_ALL, 32'd0, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_POS, 32'h7FFF_FFFF, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_POS, 32'h7FFF_FFFF, 5'd2));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_HEAD, 32'h8000_0000, 5'd31));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_TAIL, 32'hFFFF_FFFF, 5'd0));
        for (int i = 0; i < 14; i++) begin
            cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_POS,
                                   (i % 3 == 0) ? 32'h0 : 32'h7FFF_FFFF, 5'(i % 4 + 1)));
        end
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_HEAD, 32'd1, 5'd1));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_INS_POS, 32'd1, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_POS, 32'd0, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_POS, 32'd0, 5'd17));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_POS, 32'd0, 5'd16));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_FIRST, 32'h7FFF_FFFF, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_FIRST, 32'd12345, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_ALL, 32'h7FFF_FFFF, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_TAIL, 32'd0, 5'd0));
        cmd_q.push_back(mk_cmd(llpm_pkg::MODE_DEL_HEAD, 32'd0, 5'd0));

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 68;
                recv_idle_pct = 13;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 310; n++) begin
                while (cmd_q.size() > 2) @(posedge i_clk);
                // Length is known exactly only once predictions catch up;
                // an estimate from the driven side is good enough for bias.
                len_shadow = chain_len();
                c = rand_cmd();
                cmd_q.push_back(c);
                @(posedge i_clk);
            end
        end
        stim_done = 1'b1;
    end

    // Driver: holds a command steady until the block takes it, then predicts.
    always @(posedge i_clk) begin
        llpm_pkg::t_out r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                r = apply_cmd(i_in_data);
                result_q.push_back(r);
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_data <= cmd_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && cmd_q.size() > 0
                         && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= cmd_q.pop_front();
            end
        end
    end

    // Monitor: random backpressure and field-by-field comparison.
    always @(posedge i_clk) begin
        llpm_pkg::t_out exp_r;
        if (i_rst_n) begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result status=%0d slot=%0d removed=%0d",
                           o_out_data.status, o_out_data.slot, o_out_data.removed);
                    err_cnt++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (o_out_data.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status,
                               o_out_data.status);
                        err_cnt++;
                    end
                    if (o_out_data.slot !== exp_r.slot) begin
                        $error("slot expected %0d actual %0d", exp_r.slot, o_out_data.slot);
                        err_cnt++;
                    end
                    if (o_out_data.removed !== exp_r.removed) begin
                        $error("removed expected %0d actual %0d", exp_r.removed,
                               o_out_data.removed);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog and end of run: once every command is taken and every result
    // checked, allow a drain window for stray outputs before the verdict.
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > MAX_CYC) begin
                $display("DONE: errors detected");
                $finish;
            end
            if (stim_done && cmd_q.size() == 0 && !i_in_valid && result_q.size() == 0) begin
                repeat (100) @(posedge i_clk);
                if (err_cnt == 0 && result_q.size() == 0) begin
                    $display("DONE: 0 errors");
                end else begin
                    $display("DONE: errors detected");
                end
                $finish;
            end
        end
    end
endmodule
